// ===== hw/rtl/rgpc_pkg.sv =====
package rgpc_pkg;

   // field widths
   localparam int RANGE_BITS  = 17;
   localparam int HEIGHT_BITS = 16;
   localparam int HIST_BITS   = 17;  // stored previous height
   localparam int DIFF_BITS   = 18;  // gaps and height differences
   localparam int TAN_BITS    = 16;
   localparam int PROD_BITS   = TAN_BITS + RANGE_BITS;
   localparam int FRAC_BITS   = 12;
   localparam int THR_BITS    = PROD_BITS - FRAC_BITS;
   localparam int SENSOR_BITS = 13;
   localparam int MINH_BITS   = 12;
   localparam int CLOSE_BITS  = 12;
   localparam int RECLASS_BITS = 16;

   localparam int INDEX_BITS_DEFAULT = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   // register reset values
   localparam logic [SENSOR_BITS-1:0]  SENSOR_HEIGHT_RESET = 13'd300;
   localparam logic [TAN_BITS-1:0]     LOCAL_TAN_RESET     = 16'd576;
   localparam logic [TAN_BITS-1:0]     GENERAL_TAN_RESET   = 16'd358;
   localparam logic [MINH_BITS-1:0]    MIN_HEIGHT_RESET    = 12'd50;
   localparam logic [CLOSE_BITS-1:0]   CLOSE_GAP_RESET     = 12'd10;
   localparam logic [RECLASS_BITS-1:0] RECLASS_GAP_RESET   = 16'd200;

   // previous height after reset: minus the reset sensor height
   localparam logic signed [HIST_BITS-1:0] LAST_HEIGHT_RESET = -17'sd300;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SENSOR_HEIGHT = 3'd0,
      CSR_LOCAL_TAN     = 3'd1,
      CSR_GENERAL_TAN   = 3'd2,
      CSR_MIN_HEIGHT    = 3'd3,
      CSR_CLOSE_GAP     = 3'd4,
      CSR_RECLASS_GAP   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SENSOR_BITS-1:0]  sensor_height_mm;
      logic [TAN_BITS-1:0]     local_slope_tan;
      logic [TAN_BITS-1:0]     general_slope_tan;
      logic [MINH_BITS-1:0]    min_height_mm;
      logic [CLOSE_BITS-1:0]   close_gap_mm;
      logic [RECLASS_BITS-1:0] reclass_gap_mm;
   } cfg_type;

   // per-item verdicts handed from front to back
   typedef struct packed {
      logic ray_start;
      logic local_ok;    // within local band of previous point
      logic general_ok;  // within general band around ground level
      logic reclass_ok;  // far gap and within local band around ground level
   } flags_type;

   // |d| <= thr
   function automatic logic within_band(input logic signed [DIFF_BITS-1:0] d,
                                        input logic [THR_BITS-1:0] thr);
      logic signed [THR_BITS+1:0] dd;
      logic signed [THR_BITS+1:0] tt;
      dd = {{(THR_BITS + 2 - DIFF_BITS){d[DIFF_BITS-1]}}, d};
      tt = {2'b00, thr};
      return (dd <= tt) && ((-dd) <= tt);
   endfunction

endpackage

// ===== hw/rtl/rgpc_req_if.sv =====
interface rgpc_req_if #(
   parameter int INDEX_BITS = rgpc_pkg::INDEX_BITS_DEFAULT
);
   logic                                      valid;
   logic                                      ready;
   logic                                      ray_start;
   logic [rgpc_pkg::RANGE_BITS-1:0]           range_mm;
   logic signed [rgpc_pkg::HEIGHT_BITS-1:0]   height_mm;
   logic [INDEX_BITS-1:0]                     point_index;

   modport source (output valid, ray_start, range_mm, height_mm, point_index, input ready);
   modport sink   (input valid, ray_start, range_mm, height_mm, point_index, output ready);
endinterface

// ===== hw/rtl/rgpc_rsp_if.sv =====
interface rgpc_rsp_if #(
   parameter int INDEX_BITS = rgpc_pkg::INDEX_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  is_ground;
   logic [INDEX_BITS-1:0] index_out;

   modport source (output valid, is_ground, index_out, input ready);
   modport sink   (input valid, is_ground, index_out, output ready);
endinterface

// ===== hw/rtl/rgpc_csr.sv =====
module rgpc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rgpc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [rgpc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [rgpc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output rgpc_pkg::cfg_type                    cfg
);

   rgpc_pkg::cfg_type       cfg_ff;
   rgpc_pkg::cfg_type       cfg_in;
   rgpc_pkg::csr_index_type idx;
   logic                    wr_en;

   assign idx   = rgpc_pkg::csr_index_type'(csr_paddr[rgpc_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            rgpc_pkg::CSR_SENSOR_HEIGHT:
               cfg_in.sensor_height_mm = csr_pwdata[rgpc_pkg::SENSOR_BITS-1:0];
            rgpc_pkg::CSR_LOCAL_TAN:
               cfg_in.local_slope_tan = csr_pwdata[rgpc_pkg::TAN_BITS-1:0];
            rgpc_pkg::CSR_GENERAL_TAN:
               cfg_in.general_slope_tan = csr_pwdata[rgpc_pkg::TAN_BITS-1:0];
            rgpc_pkg::CSR_MIN_HEIGHT:
               cfg_in.min_height_mm = csr_pwdata[rgpc_pkg::MINH_BITS-1:0];
            rgpc_pkg::CSR_CLOSE_GAP:
               cfg_in.close_gap_mm = csr_pwdata[rgpc_pkg::CLOSE_BITS-1:0];
            rgpc_pkg::CSR_RECLASS_GAP:
               cfg_in.reclass_gap_mm = csr_pwdata[rgpc_pkg::RECLASS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_height_mm  <= rgpc_pkg::SENSOR_HEIGHT_RESET;
         cfg_ff.local_slope_tan   <= rgpc_pkg::LOCAL_TAN_RESET;
         cfg_ff.general_slope_tan <= rgpc_pkg::GENERAL_TAN_RESET;
         cfg_ff.min_height_mm     <= rgpc_pkg::MIN_HEIGHT_RESET;
         cfg_ff.close_gap_mm      <= rgpc_pkg::CLOSE_GAP_RESET;
         cfg_ff.reclass_gap_mm    <= rgpc_pkg::RECLASS_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         rgpc_pkg::CSR_SENSOR_HEIGHT:
            csr_prdata = rgpc_pkg::CSR_DATA_BITS'(cfg_ff.sensor_height_mm);
         rgpc_pkg::CSR_LOCAL_TAN:
            csr_prdata = rgpc_pkg::CSR_DATA_BITS'(cfg_ff.local_slope_tan);
         rgpc_pkg::CSR_GENERAL_TAN:
            csr_prdata = rgpc_pkg::CSR_DATA_BITS'(cfg_ff.general_slope_tan);
         rgpc_pkg::CSR_MIN_HEIGHT:
            csr_prdata = rgpc_pkg::CSR_DATA_BITS'(cfg_ff.min_height_mm);
         rgpc_pkg::CSR_CLOSE_GAP:
            csr_prdata = rgpc_pkg::CSR_DATA_BITS'(cfg_ff.close_gap_mm);
         rgpc_pkg::CSR_RECLASS_GAP:
            csr_prdata = rgpc_pkg::CSR_DATA_BITS'(cfg_ff.reclass_gap_mm);
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== hw/rtl/rgpc_front.sv =====
module rgpc_front #(
   parameter int INDEX_BITS = rgpc_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rgpc_pkg::cfg_type                 cfg,
   rgpc_req_if.sink                          req,
   input  logic [rgpc_pkg::QCNT_BITS-1:0]    q_count,
   output logic                              push,
   output rgpc_pkg::flags_type               push_flags,
   output logic [INDEX_BITS-1:0]             push_index
);

   localparam int RB = rgpc_pkg::RANGE_BITS;
   localparam int HB = rgpc_pkg::HEIGHT_BITS;
   localparam int LB = rgpc_pkg::HIST_BITS;
   localparam int DB = rgpc_pkg::DIFF_BITS;
   localparam int TB = rgpc_pkg::THR_BITS;
   localparam int PB = rgpc_pkg::PROD_BITS;
   localparam int CB = rgpc_pkg::QCNT_BITS + 1;

   // ray history
   logic [RB-1:0]        last_range_ff;
   logic signed [LB-1:0] last_height_ff;

   // stage 0: gap and reference height
   logic                 s0_valid_ff;
   logic                 s0_start_ff;
   logic [RB-1:0]        s0_range_ff;
   logic signed [HB-1:0] s0_height_ff;
   logic signed [LB-1:0] s0_base_height_ff;
   logic signed [DB-1:0] s0_gap_ff;
   logic [INDEX_BITS-1:0] s0_index_ff;

   // stage 1: thresholds and differences
   logic                 s1_valid_ff;
   logic                 s1_start_ff;
   logic [TB-1:0]        s1_lthr_raw_ff;
   logic [TB-1:0]        s1_gthr_ff;
   logic                 s1_short_ff;
   logic                 s1_far_ff;
   logic signed [DB-1:0] s1_dh_last_ff;
   logic signed [DB-1:0] s1_dh_gnd_ff;
   logic [INDEX_BITS-1:0] s1_index_ff;

   logic                 fire;
   logic [RB-1:0]        base_range;
   logic signed [LB-1:0] base_height;
   logic signed [LB-1:0] ground_level;
   logic signed [DB-1:0] gap_in;
   logic [CB-1:0]        occupancy;
   logic [PB-1:0]        lprod;
   logic [PB-1:0]        gprod;
   logic signed [DB-1:0] dh_last;
   logic signed [DB-1:0] dh_gnd;
   logic [TB-1:0]        min_thr;
   logic [TB-1:0]        lthr;

   // reserve a queue slot for every item still in the two stages
   assign occupancy = CB'(q_count) + CB'(s0_valid_ff) + CB'(s1_valid_ff);
   assign req.ready = (occupancy < CB'(rgpc_pkg::QUEUE_DEPTH));
   assign fire      = req.valid && req.ready;

   assign ground_level = -$signed({{(LB - rgpc_pkg::SENSOR_BITS){1'b0}},
                                   cfg.sensor_height_mm});
   assign base_range   = req.ray_start ? '0 : last_range_ff;
   assign base_height  = req.ray_start ? ground_level : last_height_ff;
   assign gap_in       = $signed({1'b0, req.range_mm}) - $signed({1'b0, base_range});

   always_ff @(posedge clock) begin
      if (reset) begin
         last_range_ff  <= '0;
         last_height_ff <= rgpc_pkg::LAST_HEIGHT_RESET;
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         s0_valid_ff <= fire;
         s1_valid_ff <= s0_valid_ff;
         if (fire) begin
            last_range_ff  <= req.range_mm;
            last_height_ff <= LB'(req.height_mm);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s0_start_ff       <= req.ray_start;
         s0_range_ff       <= req.range_mm;
         s0_height_ff      <= req.height_mm;
         s0_base_height_ff <= base_height;
         s0_gap_ff         <= gap_in;
         s0_index_ff       <= req.point_index;
      end
   end

   // a negative gap is short, so its product is never used
   assign lprod = PB'(cfg.local_slope_tan) * PB'(s0_gap_ff[RB-1:0]);
   assign gprod = PB'(cfg.general_slope_tan) * PB'(s0_range_ff);
   assign dh_last = DB'(s0_height_ff) - DB'(s0_base_height_ff);
   assign dh_gnd  = DB'(s0_height_ff) +
                    $signed({{(DB - rgpc_pkg::SENSOR_BITS){1'b0}}, cfg.sensor_height_mm});

   always_ff @(posedge clock) begin
      s1_start_ff    <= s0_start_ff;
      s1_lthr_raw_ff <= lprod[PB-1:rgpc_pkg::FRAC_BITS];
      s1_gthr_ff     <= gprod[PB-1:rgpc_pkg::FRAC_BITS];
      s1_short_ff    <= s0_gap_ff <
                        $signed({{(DB - rgpc_pkg::CLOSE_BITS){1'b0}}, cfg.close_gap_mm});
      s1_far_ff      <= s0_gap_ff >
                        $signed({{(DB - rgpc_pkg::RECLASS_BITS){1'b0}}, cfg.reclass_gap_mm});
      s1_dh_last_ff  <= dh_last;
      s1_dh_gnd_ff   <= dh_gnd;
      s1_index_ff    <= s0_index_ff;
   end

   // local threshold with minimum floor, then the band tests
   assign min_thr = TB'(cfg.min_height_mm);
   assign lthr    = (s1_short_ff || (s1_lthr_raw_ff < min_thr)) ? min_thr : s1_lthr_raw_ff;

   always_comb begin
      push_flags.ray_start  = s1_start_ff;
      push_flags.local_ok   = rgpc_pkg::within_band(s1_dh_last_ff, lthr);
      push_flags.general_ok = rgpc_pkg::within_band(s1_dh_gnd_ff, s1_gthr_ff);
      push_flags.reclass_ok = s1_far_ff && rgpc_pkg::within_band(s1_dh_gnd_ff, lthr);
   end

   assign push       = s1_valid_ff;
   assign push_index = s1_index_ff;

endmodule

// ===== hw/rtl/rgpc_queue.sv =====
module rgpc_queue #(
   parameter int INDEX_BITS = rgpc_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  rgpc_pkg::flags_type               push_flags,
   input  logic [INDEX_BITS-1:0]             push_index,
   input  logic                              pop,
   output logic                              not_empty,
   output rgpc_pkg::flags_type               head_flags,
   output logic [INDEX_BITS-1:0]             head_index,
   output logic [rgpc_pkg::QCNT_BITS-1:0]    count
);

   rgpc_pkg::flags_type                    flags_ff [rgpc_pkg::QUEUE_DEPTH];
   logic [INDEX_BITS-1:0]                  index_ff [rgpc_pkg::QUEUE_DEPTH];
   logic [rgpc_pkg::QPTR_BITS-1:0]         wr_ptr_ff;
   logic [rgpc_pkg::QPTR_BITS-1:0]         wr_ptr_in;
   logic [rgpc_pkg::QPTR_BITS-1:0]         rd_ptr_ff;
   logic [rgpc_pkg::QPTR_BITS-1:0]         rd_ptr_in;
   logic [rgpc_pkg::QCNT_BITS-1:0]         count_ff;
   logic [rgpc_pkg::QCNT_BITS-1:0]         count_in;

   // wrap explicitly so any depth works
   assign wr_ptr_in = !push ? wr_ptr_ff :
      (wr_ptr_ff == rgpc_pkg::QPTR_BITS'(rgpc_pkg::QUEUE_DEPTH - 1)) ? '0 :
      wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
      (rd_ptr_ff == rgpc_pkg::QPTR_BITS'(rgpc_pkg::QUEUE_DEPTH - 1)) ? '0 :
      rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         index_ff[wr_ptr_ff] <= push_index;
      end
   end

   assign not_empty  = (count_ff != '0);
   assign head_flags = flags_ff[rd_ptr_ff];
   assign head_index = index_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ===== hw/rtl/rgpc_back.sv =====
module rgpc_back #(
   parameter int INDEX_BITS = rgpc_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  rgpc_pkg::flags_type    head_flags,
   input  logic [INDEX_BITS-1:0]  head_index,
   output logic                   pop,
   rgpc_rsp_if.source             rsp
);

   logic                  last_ground_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_ground_ff;
   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic                  chain_ground;
   logic                  ground;

   assign pop = not_empty && (!rsp_valid_ff || rsp.ready);

   // the only item-to-item dependency: the previous verdict
   assign chain_ground = last_ground_ff && !head_flags.ray_start;
   assign ground = head_flags.local_ok ? (chain_ground || head_flags.general_ok)
                                       : head_flags.reclass_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ground_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            last_ground_ff <= ground;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ground_ff <= ground;
         rsp_index_ff  <= head_index;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.is_ground = rsp_ground_ff;
   assign rsp.index_out = rsp_index_ff;

endmodule

// ===== hw/rtl/ray_ground_point_classifier_unit.sv =====
// Ray ground point classifier: takes lidar points of one ray in rising range order, one item
// per point, and returns one item per point with a ground flag and the point's index. Points
// of a ray must arrive in order; ray_start on the first point clears the history (previous
// range 0, previous height minus the sensor height, previous point not ground). Heights and
// ranges are millimetres, slope tangents Q4.12. An accepted item passes through stage 0, stage 1
// and the queue into the result register; sustained rate is one item per clock when nothing
// stalls. The front part computes gap, thresholds (two 16x17 multipliers behind registers)
// and all band tests in two stages; a four-entry queue then feeds the back part, which
// resolves the one-bit previous-ground dependency and holds the result register. Input ready
// drops when the queue plus the two front stages hold four items, so a stalled result side
// backs up into the input after at most five items (four in the queue and front stages, one
// in the result register). Registers are written through the csr_ port; write them only
// while no item is in flight.
module ray_ground_point_classifier_unit #(
   parameter int INDEX_BITS = rgpc_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   // point items in, verdict items out
   rgpc_req_if.sink                           req_chan,
   rgpc_rsp_if.source                         rsp_chan,

   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rgpc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rgpc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rgpc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   rgpc_pkg::cfg_type                 cfg;
   logic                              push;
   rgpc_pkg::flags_type               push_flags;
   logic [INDEX_BITS-1:0]             push_index;
   logic                              pop;
   logic                              not_empty;
   rgpc_pkg::flags_type               head_flags;
   logic [INDEX_BITS-1:0]             head_index;
   logic [rgpc_pkg::QCNT_BITS-1:0]    q_count;

   // configuration registers
   rgpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // front: history, thresholds, band tests
   rgpc_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_chan),
      .q_count    (q_count),
      .push       (push),
      .push_flags (push_flags),
      .push_index (push_index)
   );

   // decoupling queue
   rgpc_queue #(.INDEX_BITS(INDEX_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_flags (push_flags),
      .push_index (push_index),
      .pop        (pop),
      .not_empty  (not_empty),
      .head_flags (head_flags),
      .head_index (head_index),
      .count      (q_count)
   );

   // back: ground recurrence and result register
   rgpc_back #(.INDEX_BITS(INDEX_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head_flags (head_flags),
      .head_index (head_index),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
